// ===== hdl/ftot_pkg.sv =====
// Shared types and constants of the flow usage totalizer.
// Used by ftot_ctrl, ftot_datapath and flow_usage_totalizer_core; depends on nothing.
package ftot_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned RateW    = 16;
  localparam int unsigned QuotaW   = 27;
  localparam int unsigned TotW     = 32;
  localparam int unsigned IsumW    = 22;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned FlagW    = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 168;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 27;

  // Register reset values.
  localparam logic [RateW-1:0]  RateTapLowRst  = 16'd51;
  localparam logic [RateW-1:0]  RateTapHighRst = 16'd90;
  localparam logic [RateW-1:0]  RateShowerRst  = 16'd100;
  localparam logic [QuotaW-1:0] QuotaRst       = 27'd5000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RATE_TAP_LOW  = 2'd0,
    CFG_RATE_TAP_HIGH = 2'd1,
    CFG_RATE_SHOWER   = 2'd2,
    CFG_QUOTA         = 2'd3
  } cfg_idx_e;

  // Quota indicator levels.
  typedef enum logic [LevelW-1:0] {
    LVL_GREEN  = 2'd0,
    LVL_YELLOW = 2'd1,
    LVL_RED    = 2'd2
  } level_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_USAGE,
    ST_IND,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tick;
    logic usage;
    logic indicate;
    logic scan_start;
    logic scan_step;
    logic mul;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_sess;
    logic report;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/ftot_ctrl.sv =====
// Sequencer of the flow usage totalizer: steps each item through the datapath.
// Depends on ftot_pkg.
module ftot_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ftot_pkg::status_t status_i,
  output ftot_pkg::cmd_t    cmd_o
);

  ftot_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftot_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftot_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ftot_pkg::ST_TICK;
      end
      ftot_pkg::ST_TICK: begin
        state_d = status_i.end_sess ? ftot_pkg::ST_EMIT : ftot_pkg::ST_USAGE;
      end
      ftot_pkg::ST_USAGE: state_d = ftot_pkg::ST_IND;
      ftot_pkg::ST_IND: begin
        state_d = status_i.report ? ftot_pkg::ST_SCAN : ftot_pkg::ST_EMIT;
      end
      ftot_pkg::ST_SCAN: begin
        if (status_i.scan_last) state_d = ftot_pkg::ST_DRAIN;
      end
      ftot_pkg::ST_DRAIN: state_d = ftot_pkg::ST_MUL;
      ftot_pkg::ST_MUL:   state_d = ftot_pkg::ST_EMIT;
      ftot_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = ftot_pkg::ST_IDLE;
      end
      default: state_d = ftot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftot_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ftot_pkg::ST_TICK:  cmd_o.tick = 1'b1;
      ftot_pkg::ST_USAGE: cmd_o.usage = 1'b1;
      ftot_pkg::ST_IND: begin
        cmd_o.indicate   = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ftot_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      ftot_pkg::ST_DRAIN: cmd_o = '0;
      ftot_pkg::ST_MUL:   cmd_o.mul = 1'b1;
      ftot_pkg::ST_EMIT:  cmd_o.emit = status_i.out_free;
      default:            cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/ftot_datapath.sv =====
// Datapath of the flow usage totalizer: totals, interval buffer, report scan,
// averaging multiplier and the output register. Depends on ftot_pkg.
module ftot_datapath #(
  parameter int unsigned TICKS_PER_INTERVAL   = 12,
  parameter int unsigned INTERVALS_PER_REPORT = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ftot_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ftot_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [ftot_pkg::InDataW-1:0]     in_data_i,
  input  logic                             in_user_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ftot_pkg::OutDataW-1:0]    out_data_o,
  output logic                             out_user_o,
  input  ftot_pkg::cmd_t                   cmd_i,
  output ftot_pkg::status_t                status_o
);

  localparam int unsigned TickW  = (TICKS_PER_INTERVAL > 1) ? $clog2(TICKS_PER_INTERVAL) : 1;
  localparam int unsigned SlotW  = (INTERVALS_PER_REPORT > 1) ?
                                   $clog2(INTERVALS_PER_REPORT) : 1;
  localparam int unsigned DivL   = $clog2(INTERVALS_PER_REPORT);
  localparam int unsigned SumW   = ftot_pkg::IsumW + DivL;
  localparam int unsigned ShiftW = SumW + DivL;
  localparam int unsigned ProdW  = SumW + SumW + 1;
  localparam logic [SumW:0] RecipM =
    (SumW+1)'(((64'd1 << ShiftW) + INTERVALS_PER_REPORT - 1) / INTERVALS_PER_REPORT);
  localparam logic [TickW-1:0] LastTick = TickW'(TICKS_PER_INTERVAL - 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(INTERVALS_PER_REPORT - 1);
  localparam int unsigned PadW = ftot_pkg::OutDataW - ftot_pkg::LevelW
                                 - 3 * ftot_pkg::TotW - 3 * ftot_pkg::IsumW;

  // Configuration registers.
  logic [ftot_pkg::RateW-1:0]  rate_low_q, rate_high_q, rate_shower_q;
  logic [ftot_pkg::QuotaW-1:0] quota_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_low_q    <= ftot_pkg::RateTapLowRst;
      rate_high_q   <= ftot_pkg::RateTapHighRst;
      rate_shower_q <= ftot_pkg::RateShowerRst;
      quota_q       <= ftot_pkg::QuotaRst;
    end else if (cfg_we_i) begin
      unique case (ftot_pkg::cfg_idx_e'(cfg_idx_i))
        ftot_pkg::CFG_RATE_TAP_LOW:  rate_low_q    <= cfg_data_i[ftot_pkg::RateW-1:0];
        ftot_pkg::CFG_RATE_TAP_HIGH: rate_high_q   <= cfg_data_i[ftot_pkg::RateW-1:0];
        ftot_pkg::CFG_RATE_SHOWER:   rate_shower_q <= cfg_data_i[ftot_pkg::RateW-1:0];
        ftot_pkg::CFG_QUOTA:         quota_q       <= cfg_data_i[ftot_pkg::QuotaW-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic                       end_q;
  logic [ftot_pkg::FlagW-1:0] flags_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      end_q   <= in_user_i;
      flags_q <= in_data_i[ftot_pkg::FlagW-1:0];
    end
  end

  // Accumulation state.
  logic [ftot_pkg::TotW-1:0]  tap_q, shower_q, usage_q;
  logic [ftot_pkg::IsumW-1:0] isum_q;
  logic [TickW-1:0]           tick_q;
  logic [SlotW-1:0]           slot_q;
  logic                       bnd_q, report_q;
  ftot_pkg::level_e           ind_q;

  logic [ftot_pkg::RateW-1:0] add_low, add_high, add_shower;
  logic [ftot_pkg::TotW+1:0]  tap_sum;
  logic [ftot_pkg::TotW:0]    shower_sum, usage_sum;
  logic [ftot_pkg::IsumW:0]   isum_sum;
  logic [ftot_pkg::TotW:0]    twice_usage, quota_ext;

  always_comb begin
    add_low     = flags_q[0] ? rate_low_q : '0;
    add_high    = flags_q[1] ? rate_high_q : '0;
    add_shower  = flags_q[2] ? rate_shower_q : '0;
    tap_sum     = {2'b00, tap_q} + (ftot_pkg::TotW+2)'(add_low)
                + (ftot_pkg::TotW+2)'(add_high);
    shower_sum  = {1'b0, shower_q} + (ftot_pkg::TotW+1)'(add_shower);
    isum_sum    = {1'b0, isum_q} + (ftot_pkg::IsumW+1)'(add_low)
                + (ftot_pkg::IsumW+1)'(add_high) + (ftot_pkg::IsumW+1)'(add_shower);
    usage_sum   = {1'b0, usage_q} + (ftot_pkg::TotW+1)'(isum_q);
    twice_usage = {usage_q, 1'b0};
    quota_ext   = (ftot_pkg::TotW+1)'(quota_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q    <= '0;
      shower_q <= '0;
      usage_q  <= '0;
      isum_q   <= '0;
      tick_q   <= '0;
      slot_q   <= '0;
      bnd_q    <= 1'b0;
      report_q <= 1'b0;
      ind_q    <= ftot_pkg::LVL_GREEN;
    end else begin
      if (cmd_i.tick) begin
        if (end_q) begin
          tap_q    <= '0;
          shower_q <= '0;
          isum_q   <= '0;
          tick_q   <= '0;
          slot_q   <= '0;
          bnd_q    <= 1'b0;
          report_q <= 1'b0;
        end else begin
          tap_q    <= (|tap_sum[ftot_pkg::TotW+1:ftot_pkg::TotW]) ? '1 :
                      tap_sum[ftot_pkg::TotW-1:0];
          shower_q <= shower_sum[ftot_pkg::TotW] ? '1 : shower_sum[ftot_pkg::TotW-1:0];
          isum_q   <= isum_sum[ftot_pkg::IsumW] ? '1 : isum_sum[ftot_pkg::IsumW-1:0];
          tick_q   <= (tick_q == LastTick) ? '0 : tick_q + 1'b1;
          bnd_q    <= (tick_q == LastTick);
          report_q <= (tick_q == LastTick) && (slot_q == LastSlot);
        end
      end
      if (cmd_i.usage && bnd_q) begin
        usage_q <= usage_sum[ftot_pkg::TotW] ? '1 : usage_sum[ftot_pkg::TotW-1:0];
        isum_q  <= '0;
        slot_q  <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.indicate) begin
        // At exactly half the quota the level is held.
        priority if (usage_q > quota_ext[ftot_pkg::TotW-1:0]) begin
          ind_q <= ftot_pkg::LVL_RED;
        end else if (twice_usage > quota_ext) begin
          ind_q <= ftot_pkg::LVL_YELLOW;
        end else if (twice_usage < quota_ext) begin
          ind_q <= ftot_pkg::LVL_GREEN;
        end else begin
          ind_q <= ind_q;
        end
      end
    end
  end

  // Interval buffer: one write port, one registered read port.
  logic [ftot_pkg::IsumW-1:0] buf_mem [INTERVALS_PER_REPORT];
  logic [ftot_pkg::IsumW-1:0] rd_q;
  logic [SlotW-1:0]           rd_addr_q;
  logic                       rd_vld_q, first_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.usage && bnd_q) buf_mem[slot_q] <= isum_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) rd_q <= buf_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        rd_addr_q <= '0;
        first_q   <= 1'b1;
      end else if (cmd_i.scan_step) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      if (rd_vld_q) first_q <= 1'b0;
    end
  end

  // Running minimum, maximum and sum over the scanned entries.
  logic [ftot_pkg::IsumW-1:0] min_q, max_q;
  logic [SumW-1:0]            sum_q;
  logic [ProdW-1:0]           prod_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (first_q || (rd_q < min_q)) min_q <= rd_q;
      if (first_q || (rd_q > max_q)) max_q <= rd_q;
      sum_q <= first_q ? SumW'(rd_q) : sum_q + SumW'(rd_q);
    end
    // Division by the entry count as a multiply by its reciprocal.
    if (cmd_i.mul) prod_q <= ProdW'(sum_q) * ProdW'(RecipM);
  end

  // Output register.
  logic                        out_valid_q, out_user_q;
  logic [ftot_pkg::LevelW-1:0] out_ind_q;
  logic [ftot_pkg::TotW-1:0]   out_tap_q, out_shower_q, out_usage_q;
  logic [ftot_pkg::IsumW-1:0]  out_min_q, out_max_q, out_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_user_q   <= report_q;
      out_ind_q    <= ind_q;
      out_tap_q    <= tap_q;
      out_shower_q <= shower_q;
      out_usage_q  <= usage_q;
      out_min_q    <= report_q ? min_q : '0;
      out_max_q    <= report_q ? max_q : '0;
      out_avg_q    <= report_q ? prod_q[ShiftW +: ftot_pkg::IsumW] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = {PadW'(0), out_avg_q, out_max_q, out_min_q,
                        out_usage_q, out_shower_q, out_tap_q, out_ind_q};

  assign status_o.end_sess  = end_q;
  assign status_o.report    = report_q;
  assign status_o.scan_last = (rd_addr_q == LastSlot);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while the previous one is still waiting");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("loaded result not presented");

  a_no_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_user_q) |->
      (out_min_q == '0 && out_max_q == '0 && out_avg_q == '0))
    else $error("report fields set on a result without a report");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("interval slot beyond the buffer");

  a_report_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.indicate && report_q) |-> (slot_q == '0))
    else $error("report raised away from the end of a period");

endmodule

// ===== hdl/flow_usage_totalizer_core.sv =====
// Top level of the flow usage totalizer: stream ports, configuration port,
// controller and datapath. Depends on ftot_pkg, ftot_ctrl and ftot_datapath.
//
// Each input item is either a one-second tick carrying three flow-switch flags
// or an end-of-session command, and yields exactly one result item. A tick adds
// the configured rate of every raised flag to the saturating session tap and
// shower totals and to the running interval sum; every TICKS_PER_INTERVAL ticks
// that sum is stored in the interval buffer and added to the total usage, and
// every TICKS_PER_INTERVAL * INTERVALS_PER_REPORT ticks the result also carries
// the minimum, maximum and truncated average of the buffer with tuser set.
// The quota indicator is green below half the quota, yellow above half, red
// above the quota, and keeps its level at exactly half. An end of session clears
// the session totals, the interval sum and the tick and slot counters, keeps the
// usage and the indicator, and returns the cleared totals. Items are taken one
// at a time. An ordinary tick passes through the tick, usage, indicator and
// output steps, an end of session through the tick and output steps only, and
// a tick that closes a report period adds, before the output step, the scan
// of the buffer through its single read port, a drain step and the averaging
// multiplier; in each case the result is loaded into the output register in
// the cycle before the next item can be taken. A waiting result only holds the
// block back when the next result is ready to be loaded.
// Configuration writes take effect at the edge with cfg_we_i high and must only
// be made while the block is idle.
module flow_usage_totalizer_core #(
  parameter int unsigned TICKS_PER_INTERVAL   = 12,
  parameter int unsigned INTERVALS_PER_REPORT = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [ftot_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftot_pkg::CfgDataW-1:0] cfg_data_i,
  // Input items.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tap_low_on [0], tap_high_on [1], shower_on [2], zeros [7:3]
  input  logic [ftot_pkg::InDataW-1:0]  s_axis_tdata_i,
  // command [0]: 0 tick, 1 end of session
  input  logic                          s_axis_tuser_i,
  // Result items.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // indicator_level [1:0], session_tap_ml [33:2], session_shower_ml [65:34],
  // usage_ml [97:66], interval_min_ml [119:98], interval_max_ml [141:120],
  // interval_avg_ml [163:142], zeros [167:164]
  output logic [ftot_pkg::OutDataW-1:0] m_axis_tdata_o,
  // report_valid [0]
  output logic                          m_axis_tuser_o
);

  ftot_pkg::cmd_t    cmd;
  ftot_pkg::status_t status;

  // The controller sequences each item through the datapath steps.
  ftot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds all totals, the buffer and the output register.
  ftot_datapath #(
    .TICKS_PER_INTERVAL   (TICKS_PER_INTERVAL),
    .INTERVALS_PER_REPORT (INTERVALS_PER_REPORT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
